// ===== hdl/quantized_fir_lowpass_32tap_macros.svh =====
// Assertion macros for the quantized FIR low-pass block.
// Used by the top level, which defines clk_i and rst_ni.
`ifndef QUANTIZED_FIR_LOWPASS_32TAP_MACROS_SVH
`define QUANTIZED_FIR_LOWPASS_32TAP_MACROS_SVH

// Same-cycle implication, checked out of reset only
`define QFIR_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset only
`define QFIR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/qfir_pkg.sv =====
// Shared types, constants and the coefficient table of the quantized FIR.
// No dependencies; used by qfir_cell and the top level.
package qfir_pkg;

  localparam int TAPS       = 32;
  localparam int FRAC_BITS  = 24;
  localparam int SAMPLE_W   = 27;
  localparam int OUT_W      = 32;
  localparam int CFG_W      = 5;
  localparam int CFG_IDX_W  = 2;
  localparam int COEF_W     = 24;
  localparam int CMAG_W     = 23;
  localparam int TMAG_W     = SAMPLE_W - 1;
  localparam int PROD_W     = TMAG_W + CMAG_W;
  localparam int TRUNC_W    = PROD_W - FRAC_BITS;

  // Register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_IN_FRAC   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PROD_FRAC = 2'd1;

  localparam logic [CFG_W-1:0] IN_FRAC_RST   = 5'd18;
  localparam logic [CFG_W-1:0] PROD_FRAC_RST = 5'd24;

  // Low-pass coefficients, real value times 2^24, rounded
  localparam logic signed [COEF_W-1:0] COEF_Q24 [TAPS] = '{
    24'sd49076,    24'sd158254,   -24'sd61428,   -24'sd182586,
    -24'sd23292,   24'sd280299,   24'sd167901,   -24'sd342108,
    -24'sd418305,  24'sd317949,   24'sd804238,   -24'sd107644,
    -24'sd1433812, -24'sd600378,  24'sd3108020,  24'sd6766334,
    24'sd6766334,  24'sd3108020,  -24'sd600378,  -24'sd1433812,
    -24'sd107644,  24'sd804238,   24'sd317949,   -24'sd418305,
    -24'sd342108,  24'sd167901,   24'sd280299,   -24'sd23292,
    -24'sd182586,  -24'sd61428,   24'sd158254,   24'sd49076
  };

  // Partial sum moving down the cell row
  typedef struct packed {
    logic                    valid;
    logic signed [OUT_W-1:0] sum;
  } psum_t;

  // Ones in the fraction bits dropped when keeping 'keep' of FRAC_BITS
  function automatic logic [FRAC_BITS-1:0] frac_mask(logic [CFG_W-1:0] keep);
    logic [FRAC_BITS-1:0] ones;
    ones = '1;
    if (keep >= CFG_W'(FRAC_BITS)) begin
      return '0;
    end
    return ones >> keep;
  endfunction

endpackage

// ===== hdl/qfir_cell.sv =====
// One tap of the quantized FIR: delay-line entry, tap product with
// truncation toward zero, and a stage of the partial-sum chain. Uses qfir_pkg.
module qfir_cell import qfir_pkg::*; (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       shift_i,
  input  logic                       adv_i,
  input  logic signed [SAMPLE_W-1:0] tap_i,
  input  logic [CMAG_W-1:0]          coef_mag_i,
  input  logic                       coef_neg_i,
  input  logic [FRAC_BITS-1:0]       prod_mask_i,
  input  psum_t                      psum_i,
  output logic signed [SAMPLE_W-1:0] tap_o,
  output psum_t                      psum_o
);

  logic signed [SAMPLE_W-1:0] tap_q;
  logic                       pvalid_q;
  logic signed [OUT_W-1:0]    psum_q;
  logic [SAMPLE_W-1:0]        tap_abs;
  logic [PROD_W-1:0]          prod;
  logic [TRUNC_W-1:0]         trunc;
  logic [OUT_W-1:0]           term_mag;
  logic [OUT_W-1:0]           term;

  // Advance the delay line on each accepted item
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tap_q <= '0;
    end else if (shift_i) begin
      tap_q <= tap_i;
    end
  end

  // Sign-magnitude product, truncated toward zero
  always_comb begin
    tap_abs  = tap_q[SAMPLE_W-1] ? (SAMPLE_W'(0) - tap_q) : tap_q;
    prod     = PROD_W'(tap_abs[TMAG_W-1:0]) * PROD_W'(coef_mag_i);
    trunc    = prod[PROD_W-1:FRAC_BITS] & ~{{(TRUNC_W-FRAC_BITS){1'b0}}, prod_mask_i};
    term_mag = OUT_W'(trunc);
    term     = (tap_q[SAMPLE_W-1] ^ coef_neg_i) ? (OUT_W'(0) - term_mag) : term_mag;
  end

  // Hold the token valid while the chain is held
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pvalid_q <= 1'b0;
    end else if (adv_i) begin
      pvalid_q <= psum_i.valid;
    end
  end

  // Add this tap into the passing partial sum
  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      psum_q <= psum_i.sum + $signed(term);
    end
  end

  assign tap_o        = tap_q;
  assign psum_o.valid = pvalid_q;
  assign psum_o.sum   = psum_q;

endmodule

// ===== hdl/quantized_fir_lowpass_32tap.sv =====
// Quantized 32-tap low-pass FIR built as a row of tap cells; uses qfir_pkg and qfir_cell.
// Flow: the accepted sample sets start_q, then the partial sum walks the 32 cells
// in turn and is loaded into the output register; a held output holds the walk.
// The input stalls from acceptance until the result is loaded into the output register,
// and longer while a finished result waits on the output; one item is in flight at a time.
// Reset: delay line cleared to zero, in_frac_bits 18, product_frac_bits 24.
module quantized_fir_lowpass_32tap import qfir_pkg::*; (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic signed [SAMPLE_W-1:0] sample_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic signed [OUT_W-1:0]    filtered_o,
  output logic                       clipped_o,
  input  logic                       cfg_valid_i,
  output logic                       cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [CFG_W-1:0]           cfg_data_i
);

  `include "quantized_fir_lowpass_32tap_macros.svh"

  logic [CFG_W-1:0]           in_frac_q;
  logic [CFG_W-1:0]           prod_frac_q;
  logic                       busy_q;
  logic                       start_q;
  logic                       clip_q;
  logic                       out_valid_q;
  logic signed [OUT_W-1:0]    filtered_q;
  logic                       clipped_q;
  logic                       in_acc;
  logic                       adv;
  logic                       out_load;
  logic [FRAC_BITS-1:0]       in_mask;
  logic [FRAC_BITS-1:0]       prod_mask;
  logic [SAMPLE_W-1:0]        sample_abs;
  logic                       sample_clamp;
  logic [TMAG_W-1:0]          qmag;
  logic signed [SAMPLE_W-1:0] qsample;
  logic signed [SAMPLE_W-1:0] tap_w [TAPS+1];
  psum_t                      psum_w [TAPS+1];
  logic [TAPS-1:0]            pvalid_vec;

  // Configuration registers
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_frac_q   <= IN_FRAC_RST;
      prod_frac_q <= PROD_FRAC_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        REG_IN_FRAC:   in_frac_q   <= cfg_data_i;
        REG_PROD_FRAC: prod_frac_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign in_mask   = frac_mask(in_frac_q);
  assign prod_mask = frac_mask(prod_frac_q);

  // Quantize the incoming sample, clamp a magnitude of four
  always_comb begin
    sample_abs   = sample_i[SAMPLE_W-1] ? (SAMPLE_W'(0) - sample_i) : sample_i;
    sample_clamp = sample_abs[SAMPLE_W-1];
    qmag         = (sample_clamp ? {TMAG_W{1'b1}} : sample_abs[TMAG_W-1:0])
                   & ~{{(TMAG_W-FRAC_BITS){1'b0}}, in_mask};
    qsample      = sample_i[SAMPLE_W-1] ? (SAMPLE_W'(0) - {1'b0, qmag}) : {1'b0, qmag};
  end

  // Handshake and chain control
  assign in_stall_o = busy_q;
  assign in_acc     = in_valid_i && !in_stall_o;
  assign adv        = !(psum_w[TAPS].valid && out_valid_q && out_stall_i);
  assign out_load   = psum_w[TAPS].valid && adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      start_q <= 1'b0;
    end else begin
      start_q <= in_acc;
      if (in_acc) begin
        busy_q <= 1'b1;
      end else if (out_load) begin
        busy_q <= 1'b0;
      end
    end
  end

  // Hold the clamp flag for the item in flight
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      clip_q <= sample_clamp;
    end
  end

  // Row of tap cells
  assign tap_w[0]  = qsample;
  assign psum_w[0] = '{valid: start_q, sum: '0};

  for (genvar k = 0; k < TAPS; k++) begin : g_cell
    logic signed [COEF_W-1:0] coef;
    logic [COEF_W-1:0]        coef_abs;
    logic [CMAG_W-1:0]        coef_q;

    assign coef     = COEF_Q24[k];
    assign coef_abs = coef[COEF_W-1] ? (COEF_W'(0) - coef) : coef;
    assign coef_q   = coef_abs[CMAG_W-1:0] & ~in_mask[CMAG_W-1:0];

    qfir_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .shift_i     (in_acc),
      .adv_i       (adv),
      .tap_i       (tap_w[k]),
      .coef_mag_i  (coef_q),
      .coef_neg_i  (coef[COEF_W-1]),
      .prod_mask_i (prod_mask),
      .psum_i      (psum_w[k]),
      .tap_o       (tap_w[k+1]),
      .psum_o      (psum_w[k+1])
    );

    assign pvalid_vec[k] = psum_w[k+1].valid;
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      filtered_q <= psum_w[TAPS].sum;
      clipped_q  <= clip_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign filtered_o  = filtered_q;
  assign clipped_o   = clipped_q;

  // Checks
  `QFIR_ASSERT_NEXT(a_busy_after_accept, in_acc, in_stall_o, "input not stalled after accept")
  `QFIR_ASSERT_NOW(a_single_token, 1'b1, $onehot0({start_q, pvalid_vec}), "more than one sum in chain")
  `QFIR_ASSERT_NOW(a_token_when_busy, (start_q || (|pvalid_vec)), busy_q, "sum in chain while idle")

endmodule
